[rtl/core/tcw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the congestion window engine.
// Depends on nothing; every other file in rtl/core imports it.
package tcw_pkg;

   localparam int WINDOW_BITS = 32;
   localparam int COUNT_BITS  = 8;
   localparam int SEG_BITS    = 16;
   localparam int CMD_BITS    = 2;
   localparam int PHASE_BITS  = 2;
   localparam int CSR_BITS    = 2;
   localparam int DATA_BITS   = 32;
   localparam int DIV_STEPS   = WINDOW_BITS;
   localparam int STEP_BITS   = $clog2(DIV_STEPS);

   localparam logic [CMD_BITS-1:0] CMD_NEW_ACK = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DUP_ACK = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd2;

   localparam logic [PHASE_BITS-1:0] PHASE_SLOW     = 2'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_AVOID    = 2'd1;
   localparam logic [PHASE_BITS-1:0] PHASE_RECOVERY = 2'd2;

   localparam logic [CSR_BITS-1:0] CSR_SEGMENT_SIZE = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_THRESHOLD    = 2'd1;

   localparam logic [SEG_BITS-1:0]    SEG_RESET = 16'd1460;
   localparam logic [WINDOW_BITS-1:0] THR_RESET = 32'd65535;

   typedef struct packed {
      logic [CMD_BITS-1:0]    command;
      logic [DATA_BITS-1:0]   ack_number;
      logic [DATA_BITS-1:0]   oldest_unacked;
      logic [DATA_BITS-1:0]   advertised_window;
   } req_type;

   typedef struct packed {
      logic [WINDOW_BITS-1:0] congestion_window;
      logic [WINDOW_BITS-1:0] slow_start_threshold;
      logic [WINDOW_BITS-1:0] usable_window;
      logic [PHASE_BITS-1:0]  phase;
      logic [COUNT_BITS-1:0]  duplicate_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic div_load;
      logic div_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_divide;
   } dp_status_type;

endpackage

[rtl/core/tcw_dpath.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, window state, squarer, restoring divider
// and result register. Depends on tcw_pkg; driven by tcw_ctrl commands.
module tcw_dpath
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  req_type              req_data,
   input  logic                 csr_write,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [DATA_BITS-1:0] csr_wdata,
   output rsp_type              rsp_data
);

   localparam logic [COUNT_BITS-1:0] DUP_LIMIT = COUNT_BITS'(3);
   localparam logic [COUNT_BITS-1:0] DUP_MAX   = '1;

   function automatic logic [WINDOW_BITS-1:0] sat_add(input logic [WINDOW_BITS-1:0] a,
                                                      input logic [WINDOW_BITS-1:0] b);
      logic [WINDOW_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WINDOW_BITS] ? '1 : sum[WINDOW_BITS-1:0];
   endfunction

   req_type                 req_ff;
   logic [SEG_BITS-1:0]     seg_ff;
   logic [WINDOW_BITS-1:0]  sq_ff;
   logic [WINDOW_BITS-1:0]  rem_ff, rem_in;
   logic [WINDOW_BITS-1:0]  quo_ff, quo_in;
   logic [WINDOW_BITS-1:0]  win_ff, win_in;
   logic [WINDOW_BITS-1:0]  thr_ff, thr_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [COUNT_BITS-1:0]   dup_ff, dup_in;
   rsp_type                 rsp_ff;

   logic [WINDOW_BITS:0]    rem_shift;
   logic [WINDOW_BITS:0]    rem_diff;
   logic [WINDOW_BITS-1:0]  seg_sum;
   logic [WINDOW_BITS-1:0]  growth;
   logic [COUNT_BITS-1:0]   dup_step;
   logic [WINDOW_BITS-1:0]  usable;

   // One restoring division step per cycle; the remainder stays below the divisor.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[WINDOW_BITS-1]};
      rem_diff  = rem_shift - {1'b0, win_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = sq_ff;
      end else if (cmd.div_step) begin
         if (!rem_diff[WINDOW_BITS]) begin
            rem_in = rem_diff[WINDOW_BITS-1:0];
            quo_in = {quo_ff[WINDOW_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[WINDOW_BITS-1:0];
            quo_in = {quo_ff[WINDOW_BITS-2:0], 1'b0};
         end
      end
   end

   assign status.need_divide = (req_ff.command == CMD_NEW_ACK) && (win_ff != '0) &&
                               ((phase_ff == PHASE_AVOID) ||
                                ((phase_ff == PHASE_SLOW) && !(win_ff < thr_ff)));

   assign seg_sum  = sat_add(win_ff, WINDOW_BITS'(seg_ff));
   assign growth   = (win_ff == '0) ? seg_sum : sat_add(win_ff, quo_ff);
   assign dup_step = (req_ff.ack_number != req_ff.oldest_unacked) ? COUNT_BITS'(1) :
                     (dup_ff == DUP_MAX) ? dup_ff : dup_ff + COUNT_BITS'(1);

   always_comb begin
      win_in   = win_ff;
      thr_in   = thr_ff;
      phase_in = phase_ff;
      dup_in   = dup_ff;
      case (req_ff.command)
         CMD_NEW_ACK: begin
            case (phase_ff)
               PHASE_SLOW: begin
                  dup_in = '0;
                  if (win_ff < thr_ff) begin
                     win_in = seg_sum;
                  end else begin
                     phase_in = PHASE_AVOID;
                     win_in   = growth;
                  end
               end
               PHASE_AVOID: begin
                  dup_in = '0;
                  win_in = growth;
               end
               PHASE_RECOVERY: begin
                  dup_in   = '0;
                  phase_in = PHASE_AVOID;
                  win_in   = thr_ff;
               end
               default: ;
            endcase
         end
         CMD_DUP_ACK: begin
            case (phase_ff) inside
               PHASE_SLOW, PHASE_AVOID: begin
                  dup_in = dup_step;
                  if (dup_step >= DUP_LIMIT) begin
                     phase_in = PHASE_RECOVERY;
                     thr_in   = win_ff >> 1;
                     win_in   = win_ff >> 1;
                  end
               end
               PHASE_RECOVERY: begin
                  dup_in = dup_step;
                  win_in = seg_sum;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign usable = (win_in < req_ff.advertised_window) ? win_in : req_ff.advertised_window;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
         sq_ff  <= WINDOW_BITS'(seg_ff) * WINDOW_BITS'(seg_ff);
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.commit) begin
         rsp_ff.congestion_window    <= win_in;
         rsp_ff.slow_start_threshold <= thr_in;
         rsp_ff.usable_window        <= usable;
         rsp_ff.phase                <= phase_in;
         rsp_ff.duplicate_count      <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= SEG_RESET;
         win_ff   <= WINDOW_BITS'(SEG_RESET);
         thr_ff   <= THR_RESET;
         phase_ff <= PHASE_SLOW;
         dup_ff   <= '0;
      end else begin
         if (cmd.commit) begin
            win_ff   <= win_in;
            thr_ff   <= thr_in;
            phase_ff <= phase_in;
            dup_ff   <= dup_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_SEGMENT_SIZE: seg_ff <= csr_wdata[SEG_BITS-1:0];
               CSR_THRESHOLD:    thr_ff <= csr_wdata[WINDOW_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_div_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> (rem_ff == '0) && (quo_ff == $past(sq_ff)))
      else $error("divider load did not take the square");

   a_thr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_THRESHOLD)) |=>
         (thr_ff == $past(csr_wdata[WINDOW_BITS-1:0])))
      else $error("threshold write did not load the threshold");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (rem_ff < win_ff))
      else $error("division remainder not below the window");

endmodule

[rtl/core/tcw_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences capture, division and commit, and owns the result valid.
// Depends on tcw_pkg; drives tcw_dpath through command and status structs.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cmd.capture  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.div_load = (state_ff == ST_PREP);
   assign cmd.div_step = (state_ff == ST_DIVIDE);
   assign cmd.commit   = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            count_in = '0;
            state_in = status.need_divide ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            count_in = count_ff + STEP_BITS'(1);
            if (count_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_PREP))
      else $error("accepted word did not start processing");

   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIVIDE) && (count_ff == LAST_STEP)) |=> (state_ff == ST_FINISH))
      else $error("division did not end after its last step");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid rose without a commit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("result overwritten before it was taken");

endmodule

[rtl/core/tcp_congestion_window_control.sv]
`timescale 1ns / 1ps
// Top level of the congestion window engine: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_dpath.
//
//   channel  direction  word
//   req_     in         command, ack numbers, advertised window
//   rsp_     out        window, threshold, usable window, phase, count
//   csr_     in         register index and write data
//
// A new ACK that grows the window by segment squared over window passes through the
// one-bit-per-cycle restoring divider between acceptance and result; every other word
// skips the divider, and a new word is accepted in the cycle after commit.
// A stalled result waits in its output register while the next word is processed.
// Reset is synchronous and restores the segment size, threshold and window state.
module tcp_congestion_window_control
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [DATA_BITS-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the TCP congestion window engine: directed phase walks, the
// window and duplicate count ceilings, back-pressure and random ACK traffic.
// Depends on tcw_pkg and tcp_congestion_window_control.
module testbench;
   import tcw_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int DUP_TRIGGER   = 3;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int PRINT_LIMIT   = 100;
   localparam int RANDOM_WORDS  = 450;
   localparam int CEILING_DUPS  = 300;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_BITS-1:0]  csr_index = '0;
   logic [DATA_BITS-1:0] csr_wdata = '0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   logic [SEG_BITS-1:0]    seg_bytes;
   logic [WINDOW_BITS-1:0] cwnd;
   logic [WINDOW_BITS-1:0] ssthresh;
   logic [PHASE_BITS-1:0]  cc_phase;
   logic [COUNT_BITS-1:0]  dup_acks;
   rsp_type                expected_windows[$];

   tcp_congestion_window_control uut (.*);

   always #2 clock = ~clock;

   function automatic logic [WINDOW_BITS-1:0] add_clamped(input logic [WINDOW_BITS-1:0] a,
                                                         input logic [WINDOW_BITS-1:0] b);
      logic [WINDOW_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WINDOW_BITS] ? '1 : sum[WINDOW_BITS-1:0];
   endfunction

   function automatic logic [WINDOW_BITS-1:0] grow_avoidance();
      logic [WINDOW_BITS-1:0] square;
      square = WINDOW_BITS'(seg_bytes) * WINDOW_BITS'(seg_bytes);
      if (cwnd == '0) begin
         return add_clamped(cwnd, WINDOW_BITS'(seg_bytes));
      end
      return add_clamped(cwnd, square / cwnd);
   endfunction

   function automatic void count_duplicate(input logic [DATA_BITS-1:0] ack,
                                           input logic [DATA_BITS-1:0] una);
      if (ack == una) begin
         if (dup_acks != '1) begin
            dup_acks = dup_acks + 1'b1;
         end
      end else begin
         dup_acks = COUNT_BITS'(1);
      end
   endfunction

   function automatic rsp_type predict_event(input req_type w);
      rsp_type r;
      case (w.command)
         CMD_NEW_ACK: begin
            if (cc_phase == PHASE_SLOW) begin
               if (cwnd < ssthresh) begin
                  cwnd = add_clamped(cwnd, WINDOW_BITS'(seg_bytes));
               end else begin
                  cc_phase = PHASE_AVOID;
                  cwnd = grow_avoidance();
               end
               dup_acks = '0;
            end else if (cc_phase == PHASE_AVOID) begin
               cwnd = grow_avoidance();
               dup_acks = '0;
            end else if (cc_phase == PHASE_RECOVERY) begin
               cc_phase = PHASE_AVOID;
               cwnd = ssthresh;
               dup_acks = '0;
            end
         end
         CMD_DUP_ACK: begin
            if (cc_phase == PHASE_SLOW || cc_phase == PHASE_AVOID) begin
               count_duplicate(w.ack_number, w.oldest_unacked);
               if (dup_acks >= DUP_TRIGGER) begin
                  cc_phase = PHASE_RECOVERY;
                  ssthresh = cwnd >> 1;
                  cwnd = ssthresh;
               end
            end else if (cc_phase == PHASE_RECOVERY) begin
               count_duplicate(w.ack_number, w.oldest_unacked);
               cwnd = add_clamped(cwnd, WINDOW_BITS'(seg_bytes));
            end
         end
         default: begin
         end
      endcase
      r.congestion_window    = cwnd;
      r.slow_start_threshold = ssthresh;
      r.usable_window        = (cwnd < w.advertised_window) ? cwnd : w.advertised_window;
      r.phase                = cc_phase;
      r.duplicate_count      = dup_acks;
      return r;
   endfunction

   function automatic req_type make_word(input logic [CMD_BITS-1:0] command,
                                         input logic [DATA_BITS-1:0] ack,
                                         input logic [DATA_BITS-1:0] una,
                                         input logic [DATA_BITS-1:0] adv);
      req_type w;
      w.command           = command;
      w.ack_number        = ack;
      w.oldest_unacked    = una;
      w.advertised_window = adv;
      return w;
   endfunction

   // Duplicates mostly repeat the oldest unacknowledged number so that runs of
   // three are common and fast recovery is reached often.
   function automatic req_type random_word();
      req_type w;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         w.command = CMD_NEW_ACK;
      end else if (pick < 85) begin
         w.command = CMD_DUP_ACK;
      end else if (pick < 95) begin
         w.command = CMD_QUERY;
      end else begin
         w.command = CMD_UNUSED;
      end
      w.oldest_unacked = $urandom;
      w.ack_number = ($urandom_range(99) < 85) ? w.oldest_unacked : $urandom;
      case ($urandom_range(3))
         0, 1: w.advertised_window = $urandom;
         2: w.advertised_window = cwnd + $urandom_range(4) - 2;
         default: w.advertised_window = $urandom_range(200000);
      endcase
      return w;
   endfunction

   task automatic report_mismatch(input string message);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, message);
      end
   endtask

   task automatic check_field(input string name, input logic [WINDOW_BITS-1:0] got,
                              input logic [WINDOW_BITS-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   task automatic send_word(input req_type w);
      csr_valid <= 1'b0;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      expected_windows.push_back(predict_event(w));
   endtask

   task automatic drain_results();
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (expected_windows.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_BITS-1:0] index,
                                 input logic [DATA_BITS-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SEGMENT_SIZE: seg_bytes = value[SEG_BITS-1:0];
         CSR_THRESHOLD: ssthresh = value;
         default: begin
         end
      endcase
   endtask

   task automatic test_queries();
      send_word(make_word(CMD_QUERY, '0, '0, '0));
      send_word(make_word(CMD_QUERY, '1, '1, '1));
      send_word(make_word(CMD_UNUSED, '1, '0, 32'd1460));
   endtask

   task automatic test_slow_start();
      write_register(CSR_THRESHOLD, 32'd3000);
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      send_word(make_word(CMD_NEW_ACK, '0, '0, 32'd2920));
      send_word(make_word(CMD_NEW_ACK, '0, '0, 32'd100));
      send_word(make_word(CMD_NEW_ACK, '0, '0, '0));
   endtask

   task automatic test_duplicates();
      send_word(make_word(CMD_DUP_ACK, '1, '1, '1));
      send_word(make_word(CMD_DUP_ACK, '0, '0, '1));
      send_word(make_word(CMD_DUP_ACK, '0, '1, '1));
      send_word(make_word(CMD_DUP_ACK, 32'd5, 32'd5, '1));
      send_word(make_word(CMD_DUP_ACK, 32'd5, 32'd5, '1));
      send_word(make_word(CMD_DUP_ACK, 32'd1, 32'd2, '1));
      send_word(make_word(CMD_DUP_ACK, 32'd7, 32'd7, '1));
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      send_word(make_word(CMD_QUERY, '0, '0, 32'd1000));
   endtask

   task automatic test_zero_cases();
      write_register(CSR_SEGMENT_SIZE, '0);
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      repeat (DUP_TRIGGER) send_word(make_word(CMD_DUP_ACK, 32'd9, 32'd9, '1));
      write_register(CSR_THRESHOLD, '0);
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      write_register(CSR_SEGMENT_SIZE, 32'd65535);
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      send_word(make_word(CMD_QUERY, '0, '0, '1));
   endtask

   // An all-ones threshold taken by a new ACK in fast recovery puts the window at
   // its ceiling; a long run of duplicates then drives the duplicate count to its limit.
   task automatic test_window_ceiling();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      repeat (DUP_TRIGGER) send_word(make_word(CMD_DUP_ACK, '0, '0, '1));
      write_register(CSR_THRESHOLD, '1);
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      send_word(make_word(CMD_NEW_ACK, '0, '0, '1));
      repeat (DUP_TRIGGER) send_word(make_word(CMD_DUP_ACK, '1, '1, '1));
      repeat (CEILING_DUPS) send_word(make_word(CMD_DUP_ACK, 32'd3, 32'd3, '1));
      send_word(make_word(CMD_NEW_ACK, '0, '0, '0));
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = hold_requests + 1;
      repeat (12) send_word(random_word());
      drain_results();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [DATA_BITS-1:0] seg,
                                      input logic [DATA_BITS-1:0] thr);
      write_register(CSR_SEGMENT_SIZE, seg);
      write_register(CSR_THRESHOLD, thr);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (RANDOM_WORDS) send_word(random_word());
   endtask

   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_windows.size() == 0) begin
            report_mismatch($sformatf("result word %h arrived with none expected", rsp_data));
         end else begin
            want = expected_windows.pop_front();
            check_field("congestion_window", rsp_data.congestion_window,
                        want.congestion_window);
            check_field("slow_start_threshold", rsp_data.slow_start_threshold,
                        want.slow_start_threshold);
            check_field("usable_window", rsp_data.usable_window, want.usable_window);
            check_field("phase", WINDOW_BITS'(rsp_data.phase), WINDOW_BITS'(want.phase));
            check_field("duplicate_count", WINDOW_BITS'(rsp_data.duplicate_count),
                        WINDOW_BITS'(want.duplicate_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      seg_bytes = SEG_RESET;
      cwnd      = WINDOW_BITS'(SEG_RESET);
      ssthresh  = THR_RESET;
      cc_phase  = PHASE_SLOW;
      dup_acks  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_queries();
      test_slow_start();
      test_duplicates();
      test_zero_cases();
      test_window_ceiling();
      test_backpressure();
      test_random_traffic(34, 77, 32'd65535, '1);
      test_random_traffic(77, 34, 32'd1, '0);
      test_random_traffic(0, 0, $urandom_range(65535), $urandom);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_dpath.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcp_congestion_window_control.sv
bench/testbench.sv
